// ===== src/mqbf_pkg.sv =====
package mqbf_pkg;

    // queue set dimensions
    localparam int NUM_QUEUES      = 8;
    localparam int MAX_QUEUE_BYTES = 256;

    // fixed field widths
    localparam int FUNC_W = 2;
    localparam int QID_W  = 3;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 9;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int LG_W   = 4;

    // derived widths
    localparam int QI_W        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QB_W        = $clog2(MAX_QUEUE_BYTES);
    localparam int STORE_DEPTH = NUM_QUEUES * MAX_QUEUE_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // request operation codes
    typedef enum logic [FUNC_W-1:0] {
        F_PUT    = 2'd0,
        F_GET    = 2'd1,
        F_CREATE = 2'd2,
        F_DELETE = 2'd3
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DESC = 3'b010,
        S_DATA = 3'b100
    } t_state;

    // per-queue descriptor held in the descriptor ram
    typedef struct packed {
        logic [IDX_W-1:0] widx;
        logic [IDX_W-1:0] ridx;
        logic [CNT_W-1:0] cnt;
        logic [LG_W-1:0]  lg;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    // descriptor ram access
    typedef struct packed {
        logic            we;
        logic [QI_W-1:0] waddr;
        t_desc           wdata;
        logic [QI_W-1:0] raddr;
    } t_desc_req;

    // byte store access
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic [STORE_AW-1:0] raddr;
    } t_byte_req;

    // one result transfer
    typedef struct packed {
        logic              success;
        logic [BYTE_W-1:0] read_data;
        logic [QID_W-1:0]  created_id;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  unused_count;
    } t_result;

endpackage

// ===== src/mqbf_ram.sv =====
module mqbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mqbf_ctrl.sv =====
module mqbf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [mqbf_pkg::FUNC_W-1:0] i_func,
    input  logic [mqbf_pkg::QID_W-1:0]  i_queue_id,
    input  logic [mqbf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [mqbf_pkg::SIZE_W-1:0] i_queue_size,
    output mqbf_pkg::t_desc_req         o_desc_req,
    input  mqbf_pkg::t_desc             i_desc_rdata,
    output mqbf_pkg::t_byte_req         o_byte_req,
    input  logic [mqbf_pkg::BYTE_W-1:0] i_byte_rdata,
    output logic                        o_valid,
    output mqbf_pkg::t_result           o_result
);

    import mqbf_pkg::*;

    t_state                r_state, n_state;
    t_func                 r_func, n_func;
    logic [QID_W-1:0]      r_qid, n_qid;
    logic [BYTE_W-1:0]     r_data, n_data;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic [NUM_QUEUES-1:0] r_alloc, n_alloc;
    logic                  r_valid, n_valid;
    t_result               r_res, n_res;

    logic [QI_W-1:0]  q;
    logic             q_ok;
    logic [CNT_W-1:0] qsize;
    logic [IDX_W-1:0] qmask;
    logic             size_ok;
    logic [LG_W-1:0]  req_lg;
    logic             free_found;
    logic [QI_W-1:0]  free_slot;
    logic [CNT_W-1:0] used;

    // addressed queue and its geometry from the descriptor read
    assign q     = QI_W'(r_qid);
    assign q_ok  = (int'(r_qid) < NUM_QUEUES) && r_alloc[q];
    assign qsize = CNT_W'(1) << i_desc_rdata.lg;
    assign qmask = IDX_W'(qsize - CNT_W'(1));

    // create size check and its log2
    assign size_ok = (r_size >= SIZE_W'(2)) && (r_size <= SIZE_W'(256)) &&
                     ({1'b0, r_size} <= (SIZE_W + 1)'(MAX_QUEUE_BYTES)) &&
                     ((r_size & (r_size - SIZE_W'(1))) == '0);

    always_comb begin
        req_lg = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (r_size[i]) begin
                req_lg = LG_W'(i);
            end
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_slot  = QI_W'(i);
            end
        end
    end

    // sequencer: latch request, read-modify-write descriptor, fetch byte
    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_qid   = r_qid;
        n_data  = r_data;
        n_size  = r_size;
        n_alloc = r_alloc;
        n_valid = 1'b0;
        n_res   = r_res;
        used    = '0;

        o_desc_req.we    = 1'b0;
        o_desc_req.waddr = q;
        o_desc_req.wdata = i_desc_rdata;
        o_desc_req.raddr = QI_W'(i_queue_id);

        o_byte_req.we    = 1'b0;
        o_byte_req.waddr = STORE_AW'(int'(q) * MAX_QUEUE_BYTES +
                                     int'(i_desc_rdata.widx[QB_W-1:0]));
        o_byte_req.wdata = r_data;
        o_byte_req.raddr = STORE_AW'(int'(q) * MAX_QUEUE_BYTES +
                                     int'(i_desc_rdata.ridx[QB_W-1:0]));

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func  = t_func'(i_func);
                    n_qid   = i_queue_id;
                    n_data  = i_data_byte;
                    n_size  = i_queue_size;
                    n_state = S_DESC;
                end
            end
            S_DESC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                n_res   = '0;
                case (r_func)
                    F_PUT: begin
                        if (q_ok) begin
                            used = i_desc_rdata.cnt;
                            if (i_desc_rdata.cnt < qsize) begin
                                o_byte_req.we         = 1'b1;
                                o_desc_req.we         = 1'b1;
                                o_desc_req.wdata.widx =
                                    (i_desc_rdata.widx + IDX_W'(1)) & qmask;
                                o_desc_req.wdata.cnt  = i_desc_rdata.cnt + CNT_W'(1);
                                used                  = i_desc_rdata.cnt + CNT_W'(1);
                                n_res.success         = 1'b1;
                            end
                            n_res.used_count   = used;
                            n_res.unused_count = qsize - used;
                        end
                    end
                    F_GET: begin
                        if (q_ok) begin
                            used = i_desc_rdata.cnt;
                            if (i_desc_rdata.cnt != '0) begin
                                o_desc_req.we         = 1'b1;
                                o_desc_req.wdata.ridx =
                                    (i_desc_rdata.ridx + IDX_W'(1)) & qmask;
                                o_desc_req.wdata.cnt  = i_desc_rdata.cnt - CNT_W'(1);
                                used                  = i_desc_rdata.cnt - CNT_W'(1);
                                n_res.success         = 1'b1;
                                n_valid               = 1'b0;
                                n_state               = S_DATA;
                            end
                            n_res.used_count   = used;
                            n_res.unused_count = qsize - used;
                        end
                    end
                    F_CREATE: begin
                        if (size_ok && free_found) begin
                            n_alloc[free_slot] = 1'b1;
                            o_desc_req.we      = 1'b1;
                            o_desc_req.waddr   = free_slot;
                            o_desc_req.wdata   = '{widx: '0, ridx: '0, cnt: '0, lg: req_lg};
                            n_res.success      = 1'b1;
                            n_res.created_id   = QID_W'(free_slot);
                            n_res.unused_count = r_size;
                        end
                    end
                    F_DELETE: begin
                        if (q_ok) begin
                            n_alloc[q]    = 1'b0;
                            n_res.success = 1'b1;
                        end
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end
            S_DATA: begin
                n_res.read_data = i_byte_rdata;
                n_valid         = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alloc <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alloc <= n_alloc;
            r_valid <= n_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_qid  <= n_qid;
        r_data <= n_data;
        r_size <= n_size;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // an accepted request goes straight to the descriptor read
    a_accept_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_DESC))
        else $error("accepted request did not enter descriptor stage");

    // a result follows only the descriptor or byte fetch stage
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == S_DESC || $past(r_state) == S_DATA))
        else $error("result transfer without a finished request");

    // byte store is written only in the descriptor stage
    a_store_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte_req.we |-> (r_state == S_DESC && r_func == F_PUT))
        else $error("byte store written outside a put");

    // reported counts never exceed one queue region
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((10'(r_res.used_count) + 10'(r_res.unused_count)) <=
                     10'(MAX_QUEUE_BYTES)))
        else $error("used plus free count exceeds queue capacity");

    // failed create reports nothing
    a_create_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.success && r_func == F_CREATE) |->
            (r_res.used_count == '0 && r_res.unused_count == '0 &&
             r_res.created_id == '0))
        else $error("failed create reported nonzero fields");
`endif

endmodule

// ===== src/multi_queue_byte_fifo_top.sv =====
// Multi-queue byte fifo manager: up to eight circular byte queues in one store.
// Request channel: drive i_func, i_queue_id, i_data_byte and i_queue_size with
// start high; the request transfers on a rising edge where busy is low.
// Operations: put a byte, get a byte, create a queue (size a power of two from
// 2 to 256, lowest free slot), delete a queue.
// Result channel: o_valid is high for exactly one cycle with o_success,
// o_read_data, o_created_id, o_used_count and o_unused_count; the receiver
// must take it in that cycle, there is no back pressure.
// Put, create and delete register their result in the descriptor stage; a
// successful get adds a byte fetch stage for the registered read of the byte
// store. The descriptor ram read at transfer and its write back in the
// following cycle mean no new request is taken until the last one is done;
// busy is high while a request is in flight.
// Reset (synchronous, active low) frees all queues and drops any pending
// result; the descriptor and byte stores need no clearing since every queue
// descriptor is rewritten on create and a get only reads bytes already put.
module multi_queue_byte_fifo_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mqbf_pkg::FUNC_W-1:0] i_func,
    input  logic [mqbf_pkg::QID_W-1:0]  i_queue_id,
    input  logic [mqbf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [mqbf_pkg::SIZE_W-1:0] i_queue_size,
    output logic                        o_valid,
    output logic                        o_success,
    output logic [mqbf_pkg::BYTE_W-1:0] o_read_data,
    output logic [mqbf_pkg::QID_W-1:0]  o_created_id,
    output logic [mqbf_pkg::CNT_W-1:0]  o_used_count,
    output logic [mqbf_pkg::CNT_W-1:0]  o_unused_count
);

    import mqbf_pkg::*;

    t_desc_req         desc_req;
    logic [DESC_W-1:0] desc_rdata;
    t_byte_req         byte_req;
    logic [BYTE_W-1:0] byte_rdata;
    t_result           result;

    // request sequencer and allocation bits
    mqbf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_func       (i_func),
        .i_queue_id   (i_queue_id),
        .i_data_byte  (i_data_byte),
        .i_queue_size (i_queue_size),
        .o_desc_req   (desc_req),
        .i_desc_rdata (t_desc'(desc_rdata)),
        .o_byte_req   (byte_req),
        .i_byte_rdata (byte_rdata),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    // per-queue descriptors
    mqbf_ram #(
        .WIDTH (DESC_W),
        .DEPTH (NUM_QUEUES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_req.we),
        .i_waddr (desc_req.waddr),
        .i_wdata (desc_req.wdata),
        .i_raddr (desc_req.raddr),
        .o_rdata (desc_rdata)
    );

    // byte storage, one region per queue
    mqbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_req.we),
        .i_waddr (byte_req.waddr),
        .i_wdata (byte_req.wdata),
        .i_raddr (byte_req.raddr),
        .o_rdata (byte_rdata)
    );

    assign o_success      = result.success;
    assign o_read_data    = result.read_data;
    assign o_created_id   = result.created_id;
    assign o_used_count   = result.used_count;
    assign o_unused_count = result.unused_count;

endmodule
